>>> design/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is asserted
`define NSC_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// clocked assertion on the block clock and reset
`define NSC_ASSERT(label, prop, msg) \
    `NSC_ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

>>> design/nsc_pkg.sv
// shared constants, types and helpers of the nmea sentence collector
package nsc_pkg;

    localparam int LINE_MAX_DEFAULT    = 128;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [6:0] MIN_LEN_RESET = 7'd10;
    localparam int         TAG_LEN       = 6;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;

    localparam logic [47:0] TAG_GGA = 48'h24474E474741;
    localparam logic [47:0] TAG_RMC = 48'h24474E524D43;
    localparam logic [47:0] TAG_ATT = 48'h244750415454;

    localparam logic [1:0] TYPE_IGNORED = 2'd0;
    localparam logic [1:0] TYPE_GGA     = 2'd1;
    localparam logic [1:0] TYPE_RMC     = 2'd2;
    localparam logic [1:0] TYPE_ATT     = 2'd3;

    localparam logic [1:0] STATUS_MATCH     = 2'd0;
    localparam logic [1:0] STATUS_BAD_HEX   = 2'd1;
    localparam logic [1:0] STATUS_MISMATCH  = 2'd2;
    localparam logic [1:0] STATUS_UNCHECKED = 2'd3;

    // one ended line as the front hands it to the back
    typedef struct packed {
        logic [7:0] xsum;
        logic [7:0] len;
        logic       len_ok;
        logic [2:0] tag_hit;   // bit 0 gga, bit 1 rmc, bit 2 att
        logic [7:0] hex_hi;
        logic [7:0] hex_lo;
    } line_rec_t;

    // hex digit value, bit 4 set for a non-hex character
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            v = {1'b0, c[3:0] + 4'd9};
        end else begin
            v = 5'h10;
        end
        return v;
    endfunction

endpackage

>>> design/nsc_front.sv
// front part: takes bytes, builds the line state and emits one record per ended line
module nsc_front #(
    parameter int LINE_MAX = nsc_pkg::LINE_MAX_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [6:0]        cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_rx_byte,
    input  logic              q_full,
    output logic              q_push,
    output nsc_pkg::line_rec_t q_rec
);

    localparam int CNT_W = $clog2(LINE_MAX + 1);
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_MAX);
    localparam logic [CNT_W-1:0] CNT_TAG  = CNT_W'(nsc_pkg::TAG_LEN);

    logic [6:0]       min_len_reg;
    logic [7:0]       xor_reg;
    logic             star_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [47:0]      tag_reg;
    logic [23:0]      last_reg;

    logic             take;
    logic             is_nl;
    logic             is_star;
    logic             is_dollar;
    logic [7:0]       xor_next;
    logic             star_next;
    logic [CNT_W-1:0] cnt_next;
    logic [47:0]      tag_next;
    logic [23:0]      last_next;
    logic             line_end;
    logic [7:0]       line_xor;
    logic [CNT_W-1:0] line_cnt;
    logic [47:0]      line_tag;
    logic [23:0]      line_last;

    assign s_ready = !q_full;
    assign take    = s_valid && !q_full;

    always_comb begin
        is_nl     = (s_rx_byte == nsc_pkg::CH_LF);
        is_star   = (s_rx_byte == nsc_pkg::CH_STAR);
        is_dollar = (s_rx_byte == nsc_pkg::CH_DOLLAR);

        star_next = star_reg | is_star;
        xor_next  = (!star_reg && !is_star && !is_dollar) ? (xor_reg ^ s_rx_byte) : xor_reg;
        tag_next  = (cnt_reg < CNT_TAG) ? {tag_reg[39:0], s_rx_byte} : tag_reg;
        last_next = {last_reg[15:0], s_rx_byte};
        cnt_next  = cnt_reg + 1'b1;

        // a newline closes the line without touching its state
        line_xor  = is_nl ? xor_reg  : xor_next;
        line_cnt  = is_nl ? cnt_reg  : cnt_next;
        line_tag  = is_nl ? tag_reg  : tag_next;
        line_last = is_nl ? last_reg : last_next;
        line_end  = is_nl || (cnt_next == CNT_LAST);

        q_push        = take && line_end;
        q_rec.xsum    = line_xor;
        q_rec.len     = 8'(line_cnt);
        q_rec.len_ok  = (CMP_W'(line_cnt) > CMP_W'(min_len_reg)) && (line_cnt >= CNT_TAG);
        q_rec.tag_hit = {line_tag == nsc_pkg::TAG_ATT,
                         line_tag == nsc_pkg::TAG_RMC,
                         line_tag == nsc_pkg::TAG_GGA};
        q_rec.hex_hi  = line_last[23:16];
        q_rec.hex_lo  = line_last[15:8];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg <= nsc_pkg::MIN_LEN_RESET;
            xor_reg     <= '0;
            star_reg    <= 1'b0;
            cnt_reg     <= '0;
            tag_reg     <= '0;
            last_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                min_len_reg <= cfg_wr_data;
            end
            if (take) begin
                if (line_end) begin
                    xor_reg  <= '0;
                    star_reg <= 1'b0;
                    cnt_reg  <= '0;
                    tag_reg  <= '0;
                    last_reg <= '0;
                end else begin
                    xor_reg  <= xor_next;
                    star_reg <= star_next;
                    cnt_reg  <= cnt_next;
                    tag_reg  <= tag_next;
                    last_reg <= last_next;
                end
            end
        end
    end

endmodule

>>> design/nsc_queue.sv
// short register queue of line records between front and back
module nsc_queue #(
    parameter int DEPTH = nsc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  nsc_pkg::line_rec_t push_rec,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output nsc_pkg::line_rec_t head_rec
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    nsc_pkg::line_rec_t entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   fill_reg;

    assign full       = (fill_reg == CNT_FULL);
    assign head_valid = (fill_reg != '0);
    assign head_rec   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   fill_reg <= fill_reg + 1'b1;
                2'b01:   fill_reg <= fill_reg - 1'b1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

endmodule

>>> design/nsc_back.sv
// back part: tracks the collection order, checks the sum and holds the result register
module nsc_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  nsc_pkg::line_rec_t q_rec,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_sentence_type,
    output logic [1:0]         m_check_status,
    output logic [7:0]         m_computed_sum,
    output logic [7:0]         m_received_sum,
    output logic [7:0]         m_line_length,
    output logic               m_set_complete
);

    localparam logic [1:0] STAGE_GGA = 2'd0;
    localparam logic [1:0] STAGE_RMC = 2'd1;
    localparam logic [1:0] STAGE_ATT = 2'd2;

    logic [1:0] stage_reg;
    logic [1:0] stage_next;
    logic       m_valid_reg;
    logic [1:0] type_reg;
    logic [1:0] status_reg;
    logic [7:0] csum_reg;
    logic [7:0] rsum_reg;
    logic [7:0] len_reg;
    logic       complete_reg;

    logic       hit;
    logic       accepted;
    logic [4:0] hi_v;
    logic [4:0] lo_v;
    logic [1:0] type_next;
    logic [1:0] status_next;
    logic [7:0] rsum_next;
    logic       complete_next;

    assign q_pop = q_valid && (!m_valid_reg || m_ready);

    always_comb begin
        case (stage_reg)
            STAGE_RMC: hit = q_rec.tag_hit[1];
            STAGE_ATT: hit = q_rec.tag_hit[2];
            default:   hit = q_rec.tag_hit[0];
        endcase
        accepted = q_rec.len_ok && hit;
        hi_v     = nsc_pkg::hex_val(q_rec.hex_hi);
        lo_v     = nsc_pkg::hex_val(q_rec.hex_lo);

        type_next     = nsc_pkg::TYPE_IGNORED;
        status_next   = nsc_pkg::STATUS_UNCHECKED;
        rsum_next     = '0;
        complete_next = 1'b0;
        stage_next    = stage_reg;
        if (accepted) begin
            case (stage_reg)
                STAGE_RMC: begin
                    type_next  = nsc_pkg::TYPE_RMC;
                    stage_next = STAGE_ATT;
                end
                STAGE_ATT: begin
                    type_next     = nsc_pkg::TYPE_ATT;
                    complete_next = 1'b1;
                    stage_next    = STAGE_GGA;
                end
                default: begin
                    type_next  = nsc_pkg::TYPE_GGA;
                    stage_next = STAGE_RMC;
                end
            endcase
            if (hi_v[4] || lo_v[4]) begin
                status_next = nsc_pkg::STATUS_BAD_HEX;
            end else begin
                rsum_next   = {hi_v[3:0], lo_v[3:0]};
                status_next = (rsum_next == q_rec.xsum) ? nsc_pkg::STATUS_MATCH
                                                        : nsc_pkg::STATUS_MISMATCH;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            stage_reg   <= STAGE_GGA;
        end else begin
            if (q_pop) begin
                m_valid_reg <= 1'b1;
                stage_reg   <= stage_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            type_reg     <= type_next;
            status_reg   <= status_next;
            csum_reg     <= q_rec.xsum;
            rsum_reg     <= rsum_next;
            len_reg      <= q_rec.len;
            complete_reg <= complete_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_sentence_type = type_reg;
    assign m_check_status  = status_reg;
    assign m_computed_sum  = csum_reg;
    assign m_received_sum  = rsum_reg;
    assign m_line_length   = len_reg;
    assign m_set_complete  = complete_reg;

endmodule

>>> design/nmea_sentence_collect_and_checksum.sv
// Top level of the nmea sentence collector and checksum verifier. One received byte is
// taken every cycle; s_ready drops only when the record queue between the byte front end
// and the result back end is full, which happens when QUEUE_DEPTH ended lines wait behind
// a stalled result. A line ends at a newline or at its LINE_MAX-th byte, and its result
// is written into the record queue when the ending byte is taken, then into the result
// register when the back end pops it. Lines are matched in the order gga, rmc, att;
// min_line_length may be written at any time the block is idle and takes effect on the
// next byte.
module nmea_sentence_collect_and_checksum #(
    parameter int LINE_MAX    = nsc_pkg::LINE_MAX_DEFAULT,
    parameter int QUEUE_DEPTH = nsc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [6:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_sentence_type,
    output logic [1:0] m_check_status,
    output logic [7:0] m_computed_sum,
    output logic [7:0] m_received_sum,
    output logic [7:0] m_line_length,
    output logic       m_set_complete
);

    logic               q_full;
    logic               q_push;
    nsc_pkg::line_rec_t q_in_rec;
    logic               q_pop;
    logic               q_valid;
    nsc_pkg::line_rec_t q_head_rec;

    nsc_front #(
        .LINE_MAX (LINE_MAX)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_rec       (q_in_rec)
    );

    nsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_rec   (q_in_rec),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_rec   (q_head_rec)
    );

    nsc_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_rec           (q_head_rec),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sentence_type (m_sentence_type),
        .m_check_status  (m_check_status),
        .m_computed_sum  (m_computed_sum),
        .m_received_sum  (m_received_sum),
        .m_line_length   (m_line_length),
        .m_set_complete  (m_set_complete)
    );

endmodule

>>> design/nsc_checker.sv
// port-level checker of the nmea sentence collector and its bind
`include "assert_macros.svh"

module nsc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       cfg_wr_en,
    input logic [6:0] cfg_wr_data,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_rx_byte,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_sentence_type,
    input logic [1:0] m_check_status,
    input logic [7:0] m_computed_sum,
    input logic [7:0] m_received_sum,
    input logic [7:0] m_line_length,
    input logic       m_set_complete
);

    // a stalled result request holds
    `NSC_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_sentence_type) && $stable(m_check_status) && $stable(m_computed_sum) && $stable(m_received_sum) && $stable(m_line_length) && $stable(m_set_complete), "result changed while stalled")

    // an ignored line carries no check and no received sum
    `NSC_ASSERT(a_ignored, m_valid && m_sentence_type == nsc_pkg::TYPE_IGNORED |-> m_check_status == nsc_pkg::STATUS_UNCHECKED && m_received_sum == 8'd0 && !m_set_complete, "ignored line with check data")

    // an accepted line is always checked
    `NSC_ASSERT(a_checked, m_valid && m_sentence_type != nsc_pkg::TYPE_IGNORED |-> m_check_status != nsc_pkg::STATUS_UNCHECKED, "accepted line not checked")

    `NSC_ASSERT(a_complete, m_valid && m_set_complete |-> m_sentence_type == nsc_pkg::TYPE_ATT, "set complete without att")

    `NSC_ASSERT(a_match, m_valid && m_check_status == nsc_pkg::STATUS_MATCH |-> m_computed_sum == m_received_sum, "match reported on differing sums")

endmodule

bind nmea_sentence_collect_and_checksum nsc_checker u_checker (.*);

>>> bench/tb_nmea_sentence_collect_and_checksum.sv
// testbench for the nmea sentence collector and checksum verifier
module tb_nmea_sentence_collect_and_checksum;

    localparam int LINE_LIMIT = nsc_pkg::LINE_MAX_DEFAULT;

    typedef enum logic [1:0] {
        WANT_GGA = 2'd0,
        WANT_RMC = 2'd1,
        WANT_ATT = 2'd2
    } stage_t;

    typedef enum int {
        SUM_GOOD,
        SUM_WRONG,
        SUM_BAD_HEX,
        SUM_NO_STAR
    } sum_mode_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] status;
        logic [7:0] xsum;
        logic [7:0] rsum;
        logic [7:0] len;
        logic       done;
    } line_result_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [6:0] cfg_wr_data = 7'd0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'd0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [1:0] m_sentence_type;
    logic [1:0] m_check_status;
    logic [7:0] m_computed_sum;
    logic [7:0] m_received_sum;
    logic [7:0] m_line_length;
    logic       m_set_complete;

    nmea_sentence_collect_and_checksum dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sentence_type(m_sentence_type),
        .m_check_status (m_check_status),
        .m_computed_sum (m_computed_sum),
        .m_received_sum (m_received_sum),
        .m_line_length  (m_line_length),
        .m_set_complete (m_set_complete)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // collector state mirrored on the bench side
    logic [6:0]  min_len = nsc_pkg::MIN_LEN_RESET;
    logic [7:0]  run_xor = 8'd0;
    bit          star_seen = 1'b0;
    int          line_cnt = 0;
    logic [47:0] tag_acc = 48'd0;
    logic [23:0] tail = 24'd0;
    stage_t      stage = WANT_GGA;

    line_result_t line_results[$];
    logic [7:0]   line_buf[$];
    line_result_t got_result;
    line_result_t want_result;

    int fail_count = 0;
    int bytes_sent = 0;
    int hold_off_cycles = 0;
    int stall_left = 0;
    bit tx_gap_en = 1'b0;
    bit rx_stall_en = 1'b0;

    function automatic int digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "A" && c <= "F") return c - "A" + 10;
        if (c >= "a" && c <= "f") return c - "a" + 10;
        return 16;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 10) return 8'("0" + n);
        return lower ? 8'("a" + n - 10) : 8'("A" + n - 10);
    endfunction

    function automatic logic [47:0] tag_for(input stage_t s);
        case (s)
            WANT_RMC: return nsc_pkg::TAG_RMC;
            WANT_ATT: return nsc_pkg::TAG_ATT;
            default:  return nsc_pkg::TAG_GGA;
        endcase
    endfunction

    // advance the mirrored collector by one byte, queue a result when a line ends
    function automatic void predict_byte(input logic [7:0] b);
        line_result_t r;
        int hi;
        int lo;
        if (b != nsc_pkg::CH_LF) begin
            if (b == nsc_pkg::CH_STAR) begin
                star_seen = 1'b1;
            end else if (!star_seen && b != nsc_pkg::CH_DOLLAR) begin
                run_xor ^= b;
            end
            if (line_cnt < nsc_pkg::TAG_LEN) tag_acc = {tag_acc[39:0], b};
            tail = {tail[15:0], b};
            line_cnt++;
            if (line_cnt < LINE_LIMIT) return;
        end
        r = '{nsc_pkg::TYPE_IGNORED, nsc_pkg::STATUS_UNCHECKED, run_xor, 8'd0,
              8'(line_cnt), 1'b0};
        if (line_cnt > min_len && line_cnt >= nsc_pkg::TAG_LEN
                && tag_acc == tag_for(stage)) begin
            hi = digit_value(tail[23:16]);
            lo = digit_value(tail[15:8]);
            case (stage)
                WANT_RMC: begin
                    r.kind = nsc_pkg::TYPE_RMC;
                    stage = WANT_ATT;
                end
                WANT_ATT: begin
                    r.kind = nsc_pkg::TYPE_ATT;
                    r.done = 1'b1;
                    stage = WANT_GGA;
                end
                default: begin
                    r.kind = nsc_pkg::TYPE_GGA;
                    stage = WANT_RMC;
                end
            endcase
            if (hi > 15 || lo > 15) begin
                r.status = nsc_pkg::STATUS_BAD_HEX;
            end else begin
                r.rsum = 8'(hi * 16 + lo);
                r.status = (r.rsum == run_xor) ? nsc_pkg::STATUS_MATCH
                                               : nsc_pkg::STATUS_MISMATCH;
            end
        end
        line_results.push_back(r);
        run_xor = 8'd0;
        star_seen = 1'b0;
        line_cnt = 0;
        tag_acc = 48'd0;
        tail = 24'd0;
    endfunction

    function automatic void start_sentence(input logic [47:0] tag);
        line_buf.delete();
        for (int i = 0; i < nsc_pkg::TAG_LEN; i++) line_buf.push_back(tag[47 - 8 * i -: 8]);
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endfunction

    function automatic void add_body(input int n);
        logic [7:0] c;
        repeat (n) begin
            c = 8'($urandom_range(8'h20, 8'h7E));
            if (c == nsc_pkg::CH_STAR) c = ",";
            line_buf.push_back(c);
        end
    endfunction

    // fill with any byte but newline up to the given line length
    function automatic void add_filler(input int total);
        logic [7:0] c;
        while (line_buf.size() < total) begin
            c = 8'($urandom_range(0, 255));
            if (c == nsc_pkg::CH_LF) c = 8'hFF;
            line_buf.push_back(c);
        end
    endfunction

    function automatic void finish_sentence(input sum_mode_t mode, input bit lower);
        logic [7:0] x;
        logic [7:0] bad;
        bit         hit_star;
        x = 8'd0;
        hit_star = 1'b0;
        foreach (line_buf[i]) begin
            if (line_buf[i] == nsc_pkg::CH_STAR) hit_star = 1'b1;
            else if (!hit_star && line_buf[i] != nsc_pkg::CH_DOLLAR) x ^= line_buf[i];
        end
        case ($urandom_range(0, 3))
            0:       bad = "G";
            1:       bad = "g";
            2:       bad = ":";
            default: bad = "@";
        endcase
        case (mode)
            SUM_GOOD: begin
                line_buf.push_back(nsc_pkg::CH_STAR);
                line_buf.push_back(hex_char(x[7:4], lower));
                line_buf.push_back(hex_char(x[3:0], lower));
            end
            SUM_WRONG: begin
                x ^= 8'($urandom_range(1, 255));
                line_buf.push_back(nsc_pkg::CH_STAR);
                line_buf.push_back(hex_char(x[7:4], lower));
                line_buf.push_back(hex_char(x[3:0], lower));
            end
            SUM_BAD_HEX: begin
                line_buf.push_back(nsc_pkg::CH_STAR);
                if ($urandom_range(0, 1)) begin
                    line_buf.push_back(bad);
                    line_buf.push_back(hex_char(x[3:0], lower));
                end else begin
                    line_buf.push_back(hex_char(x[7:4], lower));
                    line_buf.push_back(bad);
                end
            end
            default: begin
                line_buf.push_back(hex_char(4'($urandom_range(0, 15)), lower));
                line_buf.push_back(hex_char(4'($urandom_range(0, 15)), lower));
            end
        endcase
        line_buf.push_back("\r");
        line_buf.push_back(nsc_pkg::CH_LF);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        s_valid <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        predict_byte(b);
        bytes_sent++;
        if (tx_gap_en && $urandom_range(0, 3) == 0) begin
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_buffer();
        foreach (line_buf[i]) send_byte(line_buf[i]);
    endtask

    // no line result is pending once this returns, though an unended line may still be open
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (line_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_min_len(input logic [6:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        min_len = v;
    endtask

    task automatic send_random_line();
        int        pick;
        int        n;
        sum_mode_t mode;
        pick = $urandom_range(0, 99);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
        if (pick < 72) begin
            if ($urandom_range(0, 4) != 0) start_sentence(tag_for(stage));
            else start_sentence(tag_for(stage_t'($urandom_range(0, 2))));
            add_body(n);
            case ($urandom_range(0, 9))
                0:       mode = SUM_WRONG;
                1:       mode = SUM_BAD_HEX;
                2:       mode = SUM_NO_STAR;
                default: mode = SUM_GOOD;
            endcase
            finish_sentence(mode, $urandom_range(0, 1));
        end else if (pick < 82) begin
            // sentence broken off early
            start_sentence(tag_for(stage));
            line_buf = line_buf[0:$urandom_range(0, nsc_pkg::TAG_LEN - 1)];
            add_body(n);
            line_buf.push_back(nsc_pkg::CH_LF);
        end else if (pick < 97) begin
            line_buf.delete();
            repeat ($urandom_range(0, 20)) line_buf.push_back(8'($urandom_range(0, 255)));
            line_buf.push_back(nsc_pkg::CH_LF);
        end else begin
            start_sentence(tag_for(stage));
            add_filler($urandom_range(LINE_LIMIT - 8, LINE_LIMIT + 12));
            line_buf.push_back(nsc_pkg::CH_LF);
        end
        send_buffer();
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endtask

    always @(posedge aclk) begin
        if (hold_off_cycles > 0) begin
            m_ready <= 1'b0;
            hold_off_cycles--;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if (rx_stall_en && $urandom_range(0, 3) == 0) begin
            stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 60)
                                                       : $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_result = '{m_sentence_type, m_check_status, m_computed_sum,
                           m_received_sum, m_line_length, m_set_complete};
            if (line_results.size() == 0) begin
                note_failure($sformatf("unexpected line result: type %0d status %0d len %0d",
                                       got_result.kind, got_result.status, got_result.len));
            end else begin
                want_result = line_results.pop_front();
                if (got_result.kind != want_result.kind
                        || got_result.status != want_result.status
                        || got_result.xsum != want_result.xsum
                        || got_result.rsum != want_result.rsum
                        || got_result.len != want_result.len
                        || got_result.done != want_result.done) begin
                    note_failure($sformatf({"line result mismatch: expected type %0d status %0d",
                        " sum %02h/%02h len %0d set %0b, got type %0d status %0d",
                        " sum %02h/%02h len %0d set %0b"},
                        want_result.kind, want_result.status, want_result.xsum,
                        want_result.rsum, want_result.len, want_result.done,
                        got_result.kind, got_result.status, got_result.xsum,
                        got_result.rsum, got_result.len, got_result.done));
                end
            end
        end
    end

    // default minimum length: a ten-byte sentence is dropped, eleven bytes pass
    task automatic test_reset_min_length();
        start_sentence(nsc_pkg::TAG_GGA);
        finish_sentence(SUM_GOOD, 1'b0);
        send_buffer();
        start_sentence(nsc_pkg::TAG_GGA);
        add_text(",");
        finish_sentence(SUM_GOOD, 1'b0);
        send_buffer();
        send_byte(nsc_pkg::CH_LF);
    endtask

    task automatic test_collect_order();
        wait_drained();
        set_min_len(7'd0);
        start_sentence(nsc_pkg::TAG_RMC);
        finish_sentence(SUM_GOOD, 1'b1);
        send_buffer();
        // out of order tag is skipped
        start_sentence(nsc_pkg::TAG_GGA);
        finish_sentence(SUM_GOOD, 1'b0);
        send_buffer();
        start_sentence(nsc_pkg::TAG_ATT);
        add_text("$1");
        finish_sentence(SUM_GOOD, 1'b0);
        send_buffer();
        // extra byte brings the sum to ff
        start_sentence(nsc_pkg::TAG_GGA);
        line_buf.push_back(8'hB7);
        finish_sentence(SUM_GOOD, 1'b0);
        send_buffer();
        start_sentence(nsc_pkg::TAG_RMC);
        finish_sentence(SUM_WRONG, 1'b0);
        send_buffer();
        start_sentence(nsc_pkg::TAG_ATT);
        finish_sentence(SUM_BAD_HEX, 1'b0);
        send_buffer();
        start_sentence(nsc_pkg::TAG_GGA);
        finish_sentence(SUM_NO_STAR, 1'b1);
        send_buffer();
        line_buf = '{8'h00, 8'hFF, 8'h55, 8'hAA, nsc_pkg::CH_LF};
        send_buffer();
    endtask

    task automatic test_line_cut();
        wait_drained();
        set_min_len(7'd127);
        // full-length line ends on its last byte, the newline then ends an empty line
        start_sentence(tag_for(stage));
        add_filler(LINE_LIMIT);
        send_buffer();
        send_byte(nsc_pkg::CH_LF);
        start_sentence(tag_for(stage));
        add_filler(LINE_LIMIT - 1);
        line_buf.push_back(nsc_pkg::CH_LF);
        send_buffer();
    endtask

    task automatic test_input_stall();
        wait_drained();
        set_min_len(7'd10);
        tx_gap_en = 1'b0;
        hold_off_cycles = 300;
        repeat (20) begin
            send_byte(8'($urandom_range(8'h20, 8'h7E)));
            send_byte(nsc_pkg::CH_LF);
        end
        tx_gap_en = 1'b1;
        rx_stall_en = 1'b1;
    endtask

    task automatic test_pause_until_drained();
        repeat (6) begin
            send_random_line();
            wait_drained();
            repeat ($urandom_range(0, 20)) @(posedge aclk);
        end
    endtask

    task automatic test_random_traffic();
        int stop_at;
        for (int phase = 0; phase < 4; phase++) begin
            wait_drained();
            case (phase)
                0:       set_min_len(7'd0);
                1:       set_min_len(nsc_pkg::MIN_LEN_RESET);
                2:       set_min_len(7'($urandom_range(1, 40)));
                default: set_min_len(7'($urandom_range(0, 24)));
            endcase
            // first phase runs at full rate on both sides
            tx_gap_en = (phase != 0);
            rx_stall_en = (phase != 0);
            stop_at = bytes_sent + 30;
            while (bytes_sent < stop_at) send_random_line();
        end
    endtask

    initial begin
        tx_gap_en = 1'b1;
        rx_stall_en = 1'b1;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_min_length();
        test_collect_order();
        test_line_cut();
        test_input_stall();
        test_pause_until_drained();
        test_random_traffic();
        wait_drained();
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && line_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
